/* src/lfuct_pkg.sv */
// Shared types and constants of the LFU cache table.
// Used by lfuct_cell and lfu_cache_table_top; depends on nothing else.
package lfuct_pkg;

    localparam int DEF_ENTRIES    = 16;
    localparam int DEF_COUNT_BITS = 16;
    localparam int KEY_W          = 32;
    localparam int VAL_W          = 32;
    localparam int CAP_W          = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef logic [2:0] cell_op_t;

    localparam cell_op_t OP_NONE    = 3'd0;
    localparam cell_op_t OP_MATCH   = 3'd1;  // latch key compare into hit flag
    localparam cell_op_t OP_HIT     = 3'd2;  // refresh the hit entry
    localparam cell_op_t OP_FILL    = 3'd3;  // install into a free entry
    localparam cell_op_t OP_REPLACE = 3'd4;  // install over the victim

    // Broadcast from the controller to every cell of the row.
    typedef struct packed {
        cell_op_t           op;
        logic               wr;
        logic [KEY_W-1:0]   key;
        logic [VAL_W-1:0]   value;
    } bcast_t;

endpackage

/* src/lfuct_cell.sv */
// One entry of the LFU cache table: key, value, use count and recency rank,
// plus one stage of the victim search chain. Depends on lfuct_pkg.
module lfuct_cell #(
    parameter int COUNT_BITS = 16,
    parameter int IDX_W      = 4,
    parameter int INDEX      = 0
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  lfuct_pkg::bcast_t           bcast,
    input  logic                        scan_evict,
    input  logic [IDX_W-1:0]            ref_rank,
    input  logic [IDX_W-1:0]            new_rank,
    input  logic [IDX_W-1:0]            target_idx,
    input  logic                        cand_in_found,
    input  logic [COUNT_BITS-1:0]       cand_in_count,
    input  logic [IDX_W-1:0]            cand_in_rank,
    input  logic [IDX_W-1:0]            cand_in_idx,
    output logic                        cand_out_found,
    output logic [COUNT_BITS-1:0]       cand_out_count,
    output logic [IDX_W-1:0]            cand_out_rank,
    output logic [IDX_W-1:0]            cand_out_idx,
    output logic                        valid,
    output logic                        hit,
    output logic [IDX_W-1:0]            hit_rank,
    output logic [lfuct_pkg::VAL_W-1:0] hit_value
);
    import lfuct_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

    logic                  valid_reg;
    logic                  hit_reg;
    logic [KEY_W-1:0]      key_reg;
    logic [VAL_W-1:0]      value_reg;
    logic [COUNT_BITS-1:0] count_reg;
    logic [IDX_W-1:0]      rank_reg;

    logic                  cfound_reg;
    logic [COUNT_BITS-1:0] ccount_reg;
    logic [IDX_W-1:0]      crank_reg;
    logic [IDX_W-1:0]      cidx_reg;

    logic is_target;
    logic shift_down;
    logic own_ok;
    logic own_better;

    assign is_target  = (target_idx == MY_IDX);
    assign shift_down = valid_reg && (rank_reg > ref_rank);

    // Control state: valid and hit flags.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            hit_reg   <= 1'b0;
        end else begin
            case (bcast.op)
                OP_MATCH: hit_reg <= valid_reg && (key_reg == bcast.key);
                OP_FILL, OP_REPLACE: begin
                    if (is_target) begin
                        valid_reg <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // Entry payload.
    always_ff @(posedge aclk) begin
        case (bcast.op)
            OP_HIT: begin
                if (hit_reg) begin
                    if (count_reg != '1) begin
                        count_reg <= count_reg + 1'b1;
                    end
                    rank_reg <= new_rank;
                    if (bcast.wr) begin
                        value_reg <= bcast.value;
                    end
                end else if (shift_down) begin
                    rank_reg <= rank_reg - 1'b1;
                end
            end
            OP_FILL: begin
                if (is_target) begin
                    key_reg   <= bcast.key;
                    value_reg <= bcast.value;
                    count_reg <= COUNT_BITS'(1);
                    rank_reg  <= new_rank;
                end
            end
            OP_REPLACE: begin
                if (is_target) begin
                    key_reg   <= bcast.key;
                    value_reg <= bcast.value;
                    count_reg <= COUNT_BITS'(1);
                    rank_reg  <= new_rank;
                end else if (shift_down) begin
                    rank_reg <= rank_reg - 1'b1;
                end
            end
            default: ;
        endcase
    end

    // Victim search stage: take the candidate from the left, keep the better one.
    assign own_ok     = scan_evict ? valid_reg : !valid_reg;
    assign own_better = scan_evict &&
                        ((count_reg < cand_in_count) ||
                         ((count_reg == cand_in_count) && (rank_reg < cand_in_rank)));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfound_reg <= 1'b0;
        end else begin
            cfound_reg <= cand_in_found || own_ok;
        end
    end

    always_ff @(posedge aclk) begin
        if (own_ok && (!cand_in_found || own_better)) begin
            ccount_reg <= count_reg;
            crank_reg  <= rank_reg;
            cidx_reg   <= MY_IDX;
        end else begin
            ccount_reg <= cand_in_count;
            crank_reg  <= cand_in_rank;
            cidx_reg   <= cand_in_idx;
        end
    end

    assign cand_out_found = cfound_reg;
    assign cand_out_count = ccount_reg;
    assign cand_out_rank  = crank_reg;
    assign cand_out_idx   = cidx_reg;
    assign valid          = valid_reg;
    assign hit            = hit_reg;
    assign hit_rank       = hit_reg ? rank_reg : '0;
    assign hit_value      = hit_reg ? value_reg : '0;

endmodule

/* src/lfu_cache_table_top.sv */
// Top level of the LFU cache table: request/result channels, capacity register,
// sequencer and the row of lfuct_cell entries. Depends on lfuct_pkg, lfuct_cell.
//
//   channel   ports                      payload (lowest bit first)
//   --------  -------------------------  ------------------------------------------
//   request   s_tvalid s_tready s_tuser  tuser: cmd; tdata: key, value
//             s_tdata
//   result    m_tvalid m_tready m_tdata  tdata: found, read_value, evicted, 6 zeros
//   config    cfg_wr_en cfg_wr_data      capacity, written at any enabled edge
//
// A lookup, a write hit, a write miss with capacity zero and a lookup miss each
// go from accept through the key compare in every cell to the update step.
// A write miss adds the victim search, which walks the cell chain one cell per
// cycle, and the install.
// Reset (synchronous, active low) clears all valid bits at once; no clearing pass.
// A new request is taken while the previous result still waits in the output
// register; the update step holds while that register is full and not taken.
module lfu_cache_table_top #(
    parameter int ENTRIES    = lfuct_pkg::DEF_ENTRIES,
    parameter int COUNT_BITS = lfuct_pkg::DEF_COUNT_BITS
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // configuration
    input  logic                        cfg_wr_en,
    input  logic [lfuct_pkg::CAP_W-1:0] cfg_wr_data,   // capacity
    // request channel
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic                        s_tuser,       // cmd: 0 lookup, 1 write
    input  logic [63:0]                 s_tdata,       // [31:0] key, [63:32] value
    // result channel
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [39:0]                 m_tdata        // [0] found, [32:1] read_value,
                                                       // [33] evicted, [39:34] zero
);
    import lfuct_pkg::*;

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int OCC_W = $clog2(ENTRIES + 1);
    localparam int CMP_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_MATCH   = 3'd1;
    localparam logic [2:0] ST_APPLY   = 3'd2;
    localparam logic [2:0] ST_SCAN    = 3'd3;
    localparam logic [2:0] ST_INSTALL = 3'd4;

    localparam logic [VAL_W-1:0] MISS_VALUE = '1;   // -1

    // Sequencer and request registers.
    logic [2:0]       state_reg, state_next;
    logic [CAP_W-1:0] cap_reg;
    logic [OCC_W-1:0] occ_reg, occ_next;
    logic [IDX_W-1:0] scan_cnt_reg, scan_cnt_next;
    logic             evict_mode_reg, evict_mode_next;
    logic             cmd_reg;
    logic [KEY_W-1:0] key_reg;
    logic [VAL_W-1:0] value_reg;

    // Result register.
    logic             m_valid_reg, m_valid_next;
    logic             found_reg, found_next;
    logic [VAL_W-1:0] rdval_reg, rdval_next;
    logic             ev_reg, ev_next;

    // Broadcast to the row.
    bcast_t           bcast;
    logic [IDX_W-1:0] ref_rank;
    logic [IDX_W-1:0] new_rank;

    // Row status.
    logic [ENTRIES-1:0]    valid_vec;
    logic [ENTRIES-1:0]    hit_vec;
    logic [IDX_W-1:0]      rank_arr  [ENTRIES];
    logic [VAL_W-1:0]      value_arr [ENTRIES];
    logic [IDX_W-1:0]      hit_rank;
    logic [VAL_W-1:0]      hit_value;
    logic                  any_hit;

    // Victim search chain; element 0 is the empty candidate fed to the first cell.
    logic                  ch_found [ENTRIES+1];
    logic [COUNT_BITS-1:0] ch_count [ENTRIES+1];
    logic [IDX_W-1:0]      ch_rank  [ENTRIES+1];
    logic [IDX_W-1:0]      ch_idx   [ENTRIES+1];

    logic accept;
    logic out_free;
    logic pick_free;
    logic [OCC_W-1:0] occ_less1;

    assign accept    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign out_free  = !m_valid_reg || m_tready;
    assign occ_less1 = occ_reg - 1'b1;
    assign pick_free = (CMP_W'(occ_reg) < CMP_W'(cap_reg)) &&
                       (CMP_W'(occ_reg) < CMP_W'(ENTRIES));

    assign ch_found[0] = 1'b0;
    assign ch_count[0] = '0;
    assign ch_rank[0]  = '0;
    assign ch_idx[0]   = '0;

    genvar gi;
    generate
        for (gi = 0; gi < ENTRIES; gi++) begin : g_cell
            lfuct_cell #(
                .COUNT_BITS (COUNT_BITS),
                .IDX_W      (IDX_W),
                .INDEX      (gi)
            ) u_cell (
                .aclk           (aclk),
                .aresetn        (aresetn),
                .bcast          (bcast),
                .scan_evict     (evict_mode_reg),
                .ref_rank       (ref_rank),
                .new_rank       (new_rank),
                .target_idx     (ch_idx[ENTRIES]),
                .cand_in_found  (ch_found[gi]),
                .cand_in_count  (ch_count[gi]),
                .cand_in_rank   (ch_rank[gi]),
                .cand_in_idx    (ch_idx[gi]),
                .cand_out_found (ch_found[gi+1]),
                .cand_out_count (ch_count[gi+1]),
                .cand_out_rank  (ch_rank[gi+1]),
                .cand_out_idx   (ch_idx[gi+1]),
                .valid          (valid_vec[gi]),
                .hit            (hit_vec[gi]),
                .hit_rank       (rank_arr[gi]),
                .hit_value      (value_arr[gi])
            );
        end
    endgenerate

    // Keys are unique among valid entries, so at most one cell hits: OR the
    // masked fields together.
    always_comb begin
        hit_rank  = '0;
        hit_value = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            hit_rank  = hit_rank | rank_arr[i];
            hit_value = hit_value | value_arr[i];
        end
    end

    assign any_hit = |hit_vec;

    // Capacity register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= CAP_RESET;
        end else if (cfg_wr_en) begin
            cap_reg <= cfg_wr_data;
        end
    end

    // Request registers.
    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg   <= s_tuser;
            key_reg   <= s_tdata[31:0];
            value_reg <= s_tdata[63:32];
        end
    end

    always_comb begin
        state_next      = state_reg;
        occ_next        = occ_reg;
        scan_cnt_next   = scan_cnt_reg;
        evict_mode_next = evict_mode_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        found_next      = found_reg;
        rdval_next      = rdval_reg;
        ev_next         = ev_reg;

        bcast.op    = OP_NONE;
        bcast.wr    = cmd_reg;
        bcast.key   = key_reg;
        bcast.value = value_reg;
        ref_rank    = hit_rank;
        new_rank    = occ_less1[IDX_W-1:0];

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_MATCH;
                end
            end
            ST_MATCH: begin
                // compare the key in every cell at once
                bcast.op   = OP_MATCH;
                state_next = ST_APPLY;
            end
            ST_APPLY: begin
                if (cap_reg != '0 && !any_hit && cmd_reg) begin
                    // write miss: start the victim search down the chain
                    evict_mode_next = !pick_free;
                    scan_cnt_next   = '0;
                    state_next      = ST_SCAN;
                end else if (out_free) begin
                    m_valid_next = 1'b1;
                    ev_next      = 1'b0;
                    found_next   = 1'b0;
                    rdval_next   = MISS_VALUE;
                    if (cap_reg != '0 && any_hit) begin
                        bcast.op   = OP_HIT;
                        found_next = 1'b1;
                        if (!cmd_reg) begin
                            rdval_next = hit_value;
                        end
                    end
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN: begin
                scan_cnt_next = scan_cnt_reg + 1'b1;
                if (scan_cnt_reg == IDX_W'(ENTRIES - 1)) begin
                    state_next = ST_INSTALL;
                end
            end
            ST_INSTALL: begin
                ref_rank = ch_rank[ENTRIES];
                if (!evict_mode_reg) begin
                    new_rank = occ_reg[IDX_W-1:0];
                end
                if (out_free) begin
                    bcast.op     = evict_mode_reg ? OP_REPLACE : OP_FILL;
                    occ_next     = evict_mode_reg ? occ_reg : occ_reg + 1'b1;
                    m_valid_next = 1'b1;
                    found_next   = 1'b0;
                    rdval_next   = MISS_VALUE;
                    ev_next      = evict_mode_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            occ_reg        <= '0;
            scan_cnt_reg   <= '0;
            evict_mode_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            occ_reg        <= occ_next;
            scan_cnt_reg   <= scan_cnt_next;
            evict_mode_reg <= evict_mode_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        found_reg <= found_next;
        rdval_reg <= rdval_next;
        ev_reg    <= ev_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'b0, ev_reg, rdval_reg, found_reg};

    // Keys stay unique, so a lookup never hits more than one entry.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_APPLY) |-> $onehot0(hit_vec))
        else $error("more than one entry hit");

    // Fill count tracks the valid bits.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(valid_vec) == int'(occ_reg))
        else $error("occupancy out of step with valid bits");

    // The search always ends on a usable entry.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_INSTALL) |-> ch_found[ENTRIES])
        else $error("victim search found no entry");

    // A replaced entry must have been valid; a filled one must have been free.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_INSTALL) |->
            (valid_vec[ch_idx[ENTRIES]] == evict_mode_reg))
        else $error("install target in wrong state");

    // No result is produced without a request in flight.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (!$past(m_valid_reg) && m_valid_reg) |-> (state_reg == ST_IDLE))
        else $error("result raised outside completion");

endmodule
